FILE: sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Operation and status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int POS_W    = 32;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int WIDE_W   = 64;
    localparam int STEP_W   = $clog2(POS_W);

    // Parameter defaults
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FETCH,
        S_CAPTURE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: sv/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram: entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
    parameter int DEPTH = ple_pkg::CAPACITY_DEF,
    parameter int WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/ple_mod.sv
// ----------------------------------------------------------------------------
// ple_mod: iterative remainder unit
// Restoring division of a 32-bit position by the entry count, one quotient
// bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_mod #(
    parameter int CNT_W = 7
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [ple_pkg::POS_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]         divisor,
    output logic                          done,
    output logic      [CNT_W-1:0]         remainder
);

    localparam logic [ple_pkg::STEP_W-1:0] STEP_LAST =
        ple_pkg::STEP_W'(ple_pkg::POS_W - 1);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [ple_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [ple_pkg::POS_W-1:0]    dvd_reg, dvd_next;
    logic [CNT_W-1:0]             div_reg, div_next;
    logic [CNT_W-1:0]             rem_reg, rem_next;
    logic [CNT_W:0]               trial;

    // Shift in the next dividend bit and subtract where it fits
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[ple_pkg::POS_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[ple_pkg::POS_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control in reset, datapath free-running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: sv/positional_list_engine_top.sv
// One item at a time: the next transfer is taken the cycle after the result is loaded,
// and a result still waiting in the output register holds the engine. Empty, full and
// unused-kind items go straight to the result. Get runs the 32-step remainder unit;
// shifts go through the registered-read store (a read and a write per entry).
// Reset empties the list at once; the entry store needs no clearing pass.
// ----------------------------------------------------------------------------
// positional_list_engine_top: ordered list with positional insert and remove
// Sequencer over a single entry store and an iterative remainder unit used by get.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_top #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ple_pkg::KIND_W-1:0]    kind,
    input  wire logic [ple_pkg::POS_W-1:0]     position,
    input  wire logic signed [ple_pkg::WORD_W-1:0] value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [ple_pkg::WORD_W-1:0]  data_out,
    output logic [ple_pkg::STATUS_W-1:0]       status,
    output logic [CNT_W-1:0]                   count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    ple_pkg::state_t state_reg, state_next;

    logic [ple_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic signed [ple_pkg::WORD_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0]                at_reg, at_next;
    logic [ADDR_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [ple_pkg::WORD_W-1:0]       data_reg, data_next;
    logic [ple_pkg::STATUS_W-1:0]     res_reg, res_next;

    logic                             out_valid_reg, out_valid_next;
    logic [ple_pkg::WORD_W-1:0]       data_out_reg, data_out_next;
    logic [ple_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [CNT_W-1:0]                 count_reg, count_next;

    logic                             in_fire;
    logic                             out_fire;
    logic [ADDR_W-1:0]                last_idx;

    logic                             div_start;
    logic                             div_done;
    logic [CNT_W-1:0]                 div_rem;

    logic                             wr_en;
    logic [ADDR_W-1:0]                wr_addr;
    logic [DATA_WIDTH-1:0]            wr_data;
    logic                             rd_en;
    logic [ADDR_W-1:0]                rd_addr;
    logic [DATA_WIDTH-1:0]            rd_data;

    logic signed [DATA_WIDTH-1:0]     rd_signed;
    logic signed [ple_pkg::WIDE_W-1:0] rd_wide;
    logic signed [ple_pkg::WIDE_W-1:0] val_wide;

    assign in_stall = (state_reg != ple_pkg::S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign last_idx = ADDR_W'(cnt_reg - 1'b1);

    // Sign-extend stored words and fit incoming words to the store width
    assign rd_signed = rd_data;
    assign rd_wide   = ple_pkg::WIDE_W'(rd_signed);
    assign val_wide  = ple_pkg::WIDE_W'(value_reg);

    // Sequencer: next state, datapath updates and store accesses
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        at_next        = at_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        data_next      = data_reg;
        res_next       = res_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        data_out_next  = data_out_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        div_start      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = at_reg;

        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next  = kind;
                    value_next = value;
                    data_next  = '0;
                    res_next   = ple_pkg::ST_OK;
                    unique case (kind)
                        ple_pkg::KIND_INSERT:
                        begin
                            if (cnt_reg == CNT_FULL)
                            begin
                                res_next   = ple_pkg::ST_FULL;
                                state_next = ple_pkg::S_DONE;
                            end
                            else
                            begin
                                if (position > ple_pkg::POS_W'(cnt_reg))
                                begin
                                    at_next = cnt_reg[ADDR_W-1:0];
                                end
                                else
                                begin
                                    at_next = position[ADDR_W-1:0];
                                end
                                idx_next   = cnt_reg[ADDR_W-1:0];
                                state_next = ple_pkg::S_UP_RD;
                            end
                        end
                        ple_pkg::KIND_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next   = ple_pkg::ST_EMPTY;
                                state_next = ple_pkg::S_DONE;
                            end
                            else
                            begin
                                if (position > ple_pkg::POS_W'(last_idx))
                                begin
                                    at_next = last_idx;
                                end
                                else
                                begin
                                    at_next = position[ADDR_W-1:0];
                                end
                                state_next = ple_pkg::S_FETCH;
                            end
                        end
                        ple_pkg::KIND_GET:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next   = ple_pkg::ST_EMPTY;
                                state_next = ple_pkg::S_DONE;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = ple_pkg::S_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = ple_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // Wait for position modulo count
            ple_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    at_next    = div_rem[ADDR_W-1:0];
                    state_next = ple_pkg::S_FETCH;
                end
            end

            // Read the addressed entry
            ple_pkg::S_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = at_reg;
                state_next = ple_pkg::S_CAPTURE;
            end

            ple_pkg::S_CAPTURE:
            begin
                data_next = rd_wide[ple_pkg::WORD_W-1:0];
                idx_next  = at_reg;
                if (kind_reg == ple_pkg::KIND_REMOVE)
                begin
                    state_next = ple_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = ple_pkg::S_DONE;
                end
            end

            // Insert: move entries back one place, then drop the word in
            ple_pkg::S_UP_RD:
            begin
                if (idx_reg == at_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = at_reg;
                    wr_data    = val_wide[DATA_WIDTH-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ple_pkg::S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg - 1'b1;
                    state_next = ple_pkg::S_UP_WR;
                end
            end

            ple_pkg::S_UP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data;
                idx_next   = idx_reg - 1'b1;
                state_next = ple_pkg::S_UP_RD;
            end

            // Remove: move later entries forward one place
            ple_pkg::S_DN_RD:
            begin
                if (idx_reg == last_idx)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ple_pkg::S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + 1'b1;
                    state_next = ple_pkg::S_DN_WR;
                end
            end

            ple_pkg::S_DN_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data;
                idx_next   = idx_reg + 1'b1;
                state_next = ple_pkg::S_DN_RD;
            end

            // Hand the result to the output register once it is free
            ple_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    data_out_next  = data_reg;
                    status_next    = res_reg;
                    count_next     = cnt_reg;
                    state_next     = ple_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ple_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        at_reg       <= at_next;
        idx_reg      <= idx_next;
        data_reg     <= data_next;
        res_reg      <= res_next;
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
    end

    ple_mod #(
        .CNT_W (CNT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (position),
        .divisor   (cnt_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    ple_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

FILE: bench/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: result predictor and comparator for the positional list engine
// Watches both channels, keeps its own copy of the list, predicts one result
// per accepted transfer and compares each returned result with the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_checker #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [ple_pkg::KIND_W-1:0]    kind,
    input  wire logic [ple_pkg::POS_W-1:0]     position,
    input  wire logic [ple_pkg::WORD_W-1:0]    value,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [ple_pkg::WORD_W-1:0]    data_out,
    input  wire logic [ple_pkg::STATUS_W-1:0]  status,
    input  wire logic [CNT_W-1:0]              count,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 compared
);

    typedef struct packed {
        logic [ple_pkg::WORD_W-1:0]   data;
        logic [ple_pkg::STATUS_W-1:0] status;
        logic [CNT_W-1:0]             count;
    } list_result_t;

    // Shadow copy of the list
    logic [DATA_WIDTH-1:0] words [CAPACITY];
    int unsigned           fill_level;

    // Results predicted but not yet returned, oldest first
    list_result_t          awaited_results [$];

    // Sign-extend a stored word back to the 32-bit result field
    function automatic logic [ple_pkg::WORD_W-1:0] widen(input logic [DATA_WIDTH-1:0] w);
        logic signed [ple_pkg::WIDE_W-1:0] wide;
        wide = $signed(w);
        return wide[ple_pkg::WORD_W-1:0];
    endfunction

    // Apply one operation to the shadow list and return its result
    function automatic list_result_t apply_item(input logic [ple_pkg::KIND_W-1:0] k,
                                                input logic [ple_pkg::POS_W-1:0]  p,
                                                input logic [ple_pkg::WORD_W-1:0] v);
        list_result_t                      res;
        int unsigned                       at;
        int unsigned                       last;
        int unsigned                       i;
        logic signed [ple_pkg::WIDE_W-1:0] wide;
        res.data   = '0;
        res.status = ple_pkg::ST_OK;
        case (k)
            ple_pkg::KIND_INSERT:
            begin
                if (fill_level >= CAPACITY)
                begin
                    res.status = ple_pkg::ST_FULL;
                end
                else
                begin
                    // saturate past the end so the word is appended
                    at = (p > fill_level) ? fill_level : p;
                    for (i = fill_level; i > at; i--)
                        words[i] = words[i-1];
                    wide = $signed(v);
                    words[at] = wide[DATA_WIDTH-1:0];
                    fill_level++;
                end
            end
            ple_pkg::KIND_REMOVE:
            begin
                if (fill_level == 0)
                begin
                    res.status = ple_pkg::ST_EMPTY;
                end
                else
                begin
                    last = fill_level - 1;
                    at = (p > last) ? last : p;
                    res.data = widen(words[at]);
                    for (i = at; i < last; i++)
                        words[i] = words[i+1];
                    fill_level--;
                end
            end
            ple_pkg::KIND_GET:
            begin
                if (fill_level == 0)
                    res.status = ple_pkg::ST_EMPTY;
                else
                begin
                    // wrap cyclically over the current entries
                    at = p % fill_level;
                    res.data = widen(words[at]);
                end
            end
            default: ;
        endcase
        res.count = fill_level[CNT_W-1:0];
        return res;
    endfunction

    // Count a failure, reporting only the first few in detail
    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch %0d: %s", $realtime, mismatches, msg);
    endtask

    // Compare returned transfers, then predict for newly accepted ones
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t got;
        list_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            fill_level = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.data   = data_out;
                got.status = status;
                got.count  = count;
                if (awaited_results.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result data %h status %0d count %0d",
                                            got.data, got.status, got.count));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compared++;
                    if (got.data !== want.data || got.status !== want.status ||
                        got.count !== want.count)
                        flag_mismatch($sformatf(
                            {"expected data %h status %0d count %0d, ",
                             "got data %h status %0d count %0d"},
                            want.data, want.status, want.count,
                            got.data, got.status, got.count));
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_item(kind, position, value));
            pending = awaited_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top: stimulus and verdict for the list engine
// Drives directed edge cases, then phases of fill, drain and mixed traffic
// with random gaps and output stalls; a checker module predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_list_engine_top;

    localparam int CAPACITY     = ple_pkg::CAPACITY_DEF;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [ple_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic [ple_pkg::KIND_W-1:0]     kind      = ple_pkg::KIND_INSERT;
    logic [ple_pkg::POS_W-1:0]      position  = '0;
    logic [ple_pkg::WORD_W-1:0]     value     = '0;
    logic                           out_stall = 1'b0;
    logic                           in_stall;
    logic                           out_valid;
    logic [ple_pkg::WORD_W-1:0]     data_out;
    logic [ple_pkg::STATUS_W-1:0]   status;
    logic [CNT_W-1:0]               count;

    int          mismatches;
    int          pending;
    int          compared;
    int          sent;
    int          kind_tally [4];
    int unsigned depth_guess;
    bit          calm;
    int          hold_left;

    positional_list_engine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .status    (status),
        .count     (count)
    );

    ple_checker #(
        .CAPACITY (CAPACITY)
    ) list_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_out   (data_out),
        .status     (status),
        .count      (count),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Stall the result side at random, mostly briefly
    always @(posedge clk)
    begin
        int stall_len;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 99) < 30)
        begin
            stall_len = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 3)
                                                     : $urandom_range(20, 40);
            hold_left <= stall_len - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Idle length before the next transfer
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Position biased towards the ends of the current list
    function automatic logic [ple_pkg::POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom();
            3: return depth_guess;
            4: return (depth_guess > 0) ? depth_guess - 1 : 0;
            5: return depth_guess * $urandom_range(1, 4) + $urandom_range(0, 2);
            default: return $urandom_range(0, depth_guess + 1);
        endcase
    endfunction

    // Data word, now and then an extreme
    function automatic logic [ple_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Present one transfer and hold it until accepted
    task automatic send_item(input logic [ple_pkg::KIND_W-1:0] k,
                             input logic [ple_pkg::POS_W-1:0]  p,
                             input logic [ple_pkg::WORD_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        position <= p;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        kind_tally[k]++;
        // track the fill level only to steer later choices
        if (k == ple_pkg::KIND_INSERT && depth_guess < CAPACITY)
            depth_guess++;
        else if (k == ple_pkg::KIND_REMOVE && depth_guess > 0)
            depth_guess--;
    endtask

    // One random operation with the given insert and remove weights
    task automatic send_mix(input int insert_pct, input int remove_pct);
        int                         r;
        logic [ple_pkg::KIND_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 3)
            k = KIND_UNUSED;
        else if (r < 3 + insert_pct)
            k = ple_pkg::KIND_INSERT;
        else if (r < 3 + insert_pct + remove_pct)
            k = ple_pkg::KIND_REMOVE;
        else
            k = ple_pkg::KIND_GET;
        send_item(k, pick_position(), pick_value());
    endtask

    // Stop a hung run
    initial
    begin
        #25_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int n;
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, unused kind, insert into empty, append, front and middle
        send_item(ple_pkg::KIND_REMOVE, '0, '0);
        send_item(ple_pkg::KIND_GET, '1, '0);
        send_item(KIND_UNUSED, '1, '1);
        send_item(ple_pkg::KIND_INSERT, '0, 32'h8000_0000);
        send_item(ple_pkg::KIND_INSERT, '1, 32'h7FFF_FFFF);
        send_item(ple_pkg::KIND_INSERT, '0, '1);
        send_item(ple_pkg::KIND_INSERT, 32'd1, '0);
        send_item(ple_pkg::KIND_INSERT, 32'd2, 32'h5A5A_A5A5);
        // wrapped reads
        send_item(ple_pkg::KIND_GET, '1, '0);
        send_item(ple_pkg::KIND_GET, '0, '0);
        send_item(ple_pkg::KIND_GET, 32'd5, '0);
        send_item(ple_pkg::KIND_GET, 32'h8000_0000, '1);
        send_item(KIND_UNUSED, '0, 32'h8000_0000);
        // tail past the end, front, middle, then the only entry, then remove and get when empty
        send_item(ple_pkg::KIND_REMOVE, '1, '1);
        send_item(ple_pkg::KIND_REMOVE, '0, '0);
        send_item(ple_pkg::KIND_REMOVE, 32'd1, '0);
        send_item(ple_pkg::KIND_REMOVE, 32'd1, '0);
        send_item(ple_pkg::KIND_REMOVE, 32'd7, '0);
        send_item(ple_pkg::KIND_REMOVE, '0, '0);
        send_item(ple_pkg::KIND_GET, 32'd3, '0);

        // random phases: fill to full, drain to empty, or mixed traffic
        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    while (depth_guess < CAPACITY)
                        send_mix(80, 5);
                    repeat ($urandom_range(1, 3))
                        send_mix(90, 0);
                    send_item(ple_pkg::KIND_GET, $urandom(), '0);
                end
                1:
                begin
                    while (depth_guess > 0)
                        send_mix(5, 80);
                    repeat ($urandom_range(1, 3))
                        send_mix(0, 50);
                end
                default:
                begin
                    n = $urandom_range(20, 60);
                    repeat (n)
                        send_mix(35, 30);
                end
            endcase
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain outstanding results, then allow for a late stray one
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transfers: %0d inserts, %0d removes, %0d gets, %0d unused kind",
                 sent, kind_tally[ple_pkg::KIND_INSERT], kind_tally[ple_pkg::KIND_REMOVE],
                 kind_tally[ple_pkg::KIND_GET], kind_tally[KIND_UNUSED]);
        $display("Compared %0d results, %0d mismatches, %0d results never returned",
                 compared, mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
